// File: design/sbsh_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies; imported by sbsh_ctrl, sbsh_core and the top level.
package sbsh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Sequencer commands to the datapath.
    typedef struct packed {
        logic       wr_en;      // write one byte into the block window
        logic [5:0] wr_pos;
        logic [7:0] wr_byte;
        logic       load;       // copy hash words into working variables
        logic       round_en;   // run one compression round
        logic [5:0] round_idx;
        logic       update;     // fold working variables into hash words
        logic       init;       // restore initial hash words
        logic [2:0] rd_idx;     // digest word to present
    } core_ctrl_t;

endpackage

// File: design/sbsh_core.sv
// SHA-256 datapath: 16-word block/schedule window, working variables,
// hash words and the single shared round unit. Depends on sbsh_pkg.
module sbsh_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sbsh_pkg::core_ctrl_t ctrl,
    output logic [31:0]         rd_word
);
    import sbsh_pkg::*;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    logic [15:0][31:0] w_reg;
    logic [15:0][31:0] w_next;
    logic [7:0][31:0]  v_reg;
    logic [7:0][31:0]  v_next;
    logic [7:0][31:0]  hash_reg;
    logic [7:0][31:0]  hash_next;

    logic [31:0] w_new;
    logic [31:0] sig0;
    logic [31:0] sig1;
    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [1:0]  lane_sh;

    // Round unit and rolling schedule word.
    always_comb
    begin
        sig0  = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1  = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + sig0 + w_reg[9] + sig1;
        big1  = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + K_TABLE[ctrl.round_idx] + w_reg[0];
        big0  = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = big0 + maj;
    end

    // Window: byte writes while filling, shift by one word per round.
    always_comb
    begin
        w_next  = w_reg;
        lane_sh = ~ctrl.wr_pos[1:0];
        if (ctrl.wr_en)
        begin
            w_next[ctrl.wr_pos[5:2]][{lane_sh, 3'b000} +: 8] = ctrl.wr_byte;
        end
        else if (ctrl.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = w_new;
        end
    end

    always_comb
    begin
        v_next = v_reg;
        if (ctrl.load)
        begin
            v_next = hash_reg;
        end
        else if (ctrl.round_en)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_comb
    begin
        hash_next = hash_reg;
        if (ctrl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = H_INIT[i];
            end
        end
        else if (ctrl.update)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign rd_word = hash_reg[ctrl.rd_idx];

endmodule

// File: design/sbsh_ctrl.sv
// Sequencer for the SHA-256 hasher: byte fill, padding, round count,
// message length and digest readout. Depends on sbsh_pkg.
module sbsh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 action,
    input  logic [7:0]           data_byte,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [2:0]           word_index,
    output logic                 last_word,
    output sbsh_pkg::core_ctrl_t ctrl
);
    import sbsh_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [60:0] msg_len_reg;
    logic [60:0] msg_len_next;
    logic [5:0]  pos_reg;
    logic [5:0]  pos_next;
    logic [5:0]  rnd_reg;
    logic [5:0]  rnd_next;
    logic        finish_reg;
    logic        finish_next;
    logic        mark_reg;
    logic        mark_next;
    logic        len_blk_reg;
    logic        len_blk_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;

    logic        item_acc;
    logic        result_acc;
    logic [63:0] bit_len;
    logic [63:0] len_shift;
    logic [7:0]  pad_byte;

    assign item_acc   = item_valid && (state_reg == ST_IDLE);
    assign result_acc = result_valid && !result_stall;
    assign bit_len    = {msg_len_reg, 3'b000};
    assign len_shift  = bit_len >> {~pos_reg[2:0], 3'b000};

    always_comb
    begin
        if (mark_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (len_blk_reg && (pos_reg >= LEN_POS))
        begin
            pad_byte = len_shift[7:0];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (action == ACT_FINISH)
                        state_next = ST_PAD;
                    else if (fill_reg == LAST_POS)
                        state_next = ST_ROUND;
                end
            end
            ST_PAD:
            begin
                if (pos_reg == LAST_POS)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg == LAST_ROUND)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!finish_reg)
                    state_next = ST_IDLE;
                else if (len_blk_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_PAD;
            end
            ST_OUT:
            begin
                if (result_acc && (idx_reg == LAST_WORD))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        item_stall     = (state_reg != ST_IDLE);
        result_valid   = (state_reg == ST_OUT);
        word_index     = idx_reg;
        last_word      = (idx_reg == LAST_WORD);
        ctrl           = '0;
        ctrl.round_idx = rnd_reg;
        ctrl.rd_idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.wr_en   = item_acc && (action == ACT_ABSORB);
                ctrl.wr_pos  = fill_reg;
                ctrl.wr_byte = data_byte;
                ctrl.load    = ctrl.wr_en && (fill_reg == LAST_POS);
            end
            ST_PAD:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_pos  = pos_reg;
                ctrl.wr_byte = pad_byte;
                ctrl.load    = (pos_reg == LAST_POS);
            end
            ST_ROUND:  ctrl.round_en = 1'b1;
            ST_UPDATE: ctrl.update   = 1'b1;
            ST_OUT:    ctrl.init     = result_acc && (idx_reg == LAST_WORD);
            default:   ctrl.update   = 1'b0;
        endcase
    end

    // Counters and flags.
    always_comb
    begin
        fill_next    = fill_reg;
        msg_len_next = msg_len_reg;
        pos_next     = pos_reg;
        rnd_next     = rnd_reg;
        finish_next  = finish_reg;
        mark_next    = mark_reg;
        len_blk_next = len_blk_reg;
        idx_next     = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (action == ACT_ABSORB))
                begin
                    fill_next    = fill_reg + 6'd1;
                    msg_len_next = msg_len_reg + 61'd1;
                    rnd_next     = '0;
                end
                else if (item_acc)
                begin
                    finish_next  = 1'b1;
                    mark_next    = 1'b1;
                    pos_next     = fill_reg;
                    // length fits behind the marker only below byte 56
                    len_blk_next = (fill_reg < LEN_POS);
                end
            end
            ST_PAD:
            begin
                pos_next  = pos_reg + 6'd1;
                mark_next = 1'b0;
                rnd_next  = '0;
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
            end
            ST_UPDATE:
            begin
                if (finish_reg && !len_blk_reg)
                begin
                    len_blk_next = 1'b1;
                    pos_next     = '0;
                end
            end
            ST_OUT:
            begin
                if (result_acc)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_WORD)
                    begin
                        fill_next    = '0;
                        msg_len_next = '0;
                        finish_next  = 1'b0;
                        len_blk_next = 1'b0;
                    end
                end
            end
            default: idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            msg_len_reg <= '0;
            pos_reg     <= '0;
            rnd_reg     <= '0;
            finish_reg  <= 1'b0;
            mark_reg    <= 1'b0;
            len_blk_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            msg_len_reg <= msg_len_next;
            pos_reg     <= pos_next;
            rnd_reg     <= rnd_next;
            finish_reg  <= finish_next;
            mark_reg    <= mark_next;
            len_blk_reg <= len_blk_next;
            idx_reg     <= idx_next;
        end
    end

endmodule

// File: design/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream: top level joining sequencer and datapath.
// Depends on sbsh_pkg, sbsh_ctrl and sbsh_core.
//
// Request channel: item_valid / item_stall with action and data_byte.
//   action = absorb appends data_byte to the current 64-byte block;
//   action = finish pads, appends the 64-bit bit length and hashes.
// Result channel: result_valid / result_stall with digest_word,
//   word_index and last_word; a finish yields eight words, H0 first.
//
// Timing, one request at a time (item_stall is high while busy):
//   absorb that does not fill the block: taken without going busy.
//   absorb that fills the block: accept, then 64 rounds, then the update.
//   finish with F bytes buffered: accept, padding from byte F to byte 63,
//   64 rounds, the update; if F >= 56 a second block is padded, run and updated.
//   Then the eight digest words go out, each held while the receiver stalls.
// The shared round unit does one SHA-256 round per cycle and the padding
// writes one byte per cycle into the same block window.
// result_stall holds the current digest word; nothing else moves meanwhile.
// Reset loads the initial hash values and clears length and fill count;
// after the last digest word is taken the same state is restored.
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sbsh_pkg::*;

    core_ctrl_t ctrl;

    sbsh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .action       (action),
        .data_byte    (data_byte),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .word_index   (word_index),
        .last_word    (last_word),
        .ctrl         (ctrl)
    );

    sbsh_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rd_word (digest_word)
    );

endmodule

// File: sim/sha256_byte_stream_hasher_test.sv
// Self-checking testbench for sha256_byte_stream_hasher: directed and random messages.
// Needs sbsh_pkg and the hasher RTL; expected digests come from an in-bench SHA-256 model.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;

    import sbsh_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int TARGET_REQS  = 320;
    localparam int MIN_RAND_MSG = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 150;
    localparam int MAX_REPORTS  = 10;

    // SHA-256 round constants and initial hash words, kept apart from the design's copy
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic       act;
        logic [7:0] data;
    } hash_req_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        is_last;
    } digest_word_t;

    // DUT ports; every input starts at a known value
    logic        clk;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic        action       = ACT_ABSORB;
    logic [7:0]  data_byte    = 8'h00;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // request queue filled up front, expected digest words filled on acceptance
    hash_req_t    req_q[$];
    digest_word_t digest_q[$];
    hash_req_t    next_req;

    // model state: chaining words, block buffer, fill level, byte count
    logic [31:0] sha_h [8];
    logic [7:0]  sha_blk [64];
    logic [5:0]  sha_fill;
    logic [60:0] sha_len;

    int req_total;
    int req_taken;
    int rand_msgs;
    int msg_room;
    int msgs_hashed;
    int empty_msgs;
    int short_tail_msgs;
    int words_checked;
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    logic hold_used;
    logic late_finish;

    sha256_byte_stream_hasher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    always
    begin
        clk = 1'b1;
        #(CLK_PERIOD / 2);
        clk = 1'b0;
        #(CLK_PERIOD / 2);
    end

    // ------------------------------------------------------------------
    // SHA-256 model
    // ------------------------------------------------------------------

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void sha_restart();
        for (int i = 0; i < 8; i++)
            sha_h[i] = SHA_IV[i];
        sha_fill = '0;
        sha_len  = '0;
    endfunction

    // one 64-round compression of sha_blk into sha_h
    function automatic void sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, ch, maj;
        for (int t = 0; t < 16; t++)
            w[t] = {sha_blk[4*t], sha_blk[4*t+1], sha_blk[4*t+2], sha_blk[4*t+3]};
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = sha_h[i];
        for (int t = 0; t < 64; t++)
        begin
            s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + ROUND_K[t] + w[t];
            s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            sha_h[i] = sha_h[i] + v[i];
    endfunction

    // pad, hash the last block(s), queue the eight digest words, start over
    function automatic void sha_finish();
        logic [63:0]  bit_len;
        int           k;
        digest_word_t dw;
        bit_len = {sha_len, 3'b000};
        if (sha_len == 0)
            empty_msgs++;
        sha_blk[sha_fill] = 8'h80;
        k = int'(sha_fill) + 1;
        if (k > 56)
        begin
            // short tail: no room for the length, spill into an extra block
            short_tail_msgs++;
            while (k < 64)
            begin
                sha_blk[k] = 8'h00;
                k++;
            end
            sha_compress();
            k = 0;
        end
        while (k < 56)
        begin
            sha_blk[k] = 8'h00;
            k++;
        end
        for (int i = 0; i < 8; i++)
            sha_blk[56+i] = bit_len[63-8*i -: 8];
        sha_compress();
        for (int i = 0; i < 8; i++)
        begin
            dw.word    = sha_h[i];
            dw.idx     = 3'(i);
            dw.is_last = (i == 7);
            digest_q   = {digest_q, dw};
        end
        msgs_hashed++;
        sha_restart();
    endfunction

    function automatic void sha_take_request(input logic act, input logic [7:0] data);
        if (act == ACT_ABSORB)
        begin
            sha_blk[sha_fill] = data;
            sha_fill = sha_fill + 6'd1;
            sha_len  = sha_len + 61'd1;
            if (sha_fill == 0)
                sha_compress();
        end
        else
            sha_finish();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    function automatic void queue_byte(input logic [7:0] data);
        hash_req_t r;
        r.act  = ACT_ABSORB;
        r.data = data;
        req_q  = {req_q, r};
    endfunction

    // data on a finish request must be ignored, so it gets a value too
    function automatic void queue_finish(input logic [7:0] data);
        hash_req_t r;
        r.act  = ACT_FINISH;
        r.data = data;
        req_q  = {req_q, r};
    endfunction

    // lengths lean toward the padding boundaries: 55 fits, 56..63 spill,
    // 64 and 128 end right on a block
    function automatic int pick_msg_len();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom_range(0, 8);
        if (sel < 8)
        begin
            case ($urandom_range(0, 10))
                0:       return 55;
                1:       return 56;
                2:       return 57;
                3:       return 62;
                4:       return 63;
                5:       return 64;
                6:       return 65;
                7:       return 119;
                8:       return 120;
                9:       return 127;
                default: return 128;
            endcase
        end
        return $urandom_range(0, 140);
    endfunction

    // the last message is cut short so the total stays near the target
    function automatic void queue_random_msg(input int max_len);
        int len;
        len = pick_msg_len();
        if (len > max_len)
            len = max_len;
        for (int i = 0; i < len; i++)
            queue_byte(8'($urandom_range(0, 255)));
        queue_finish(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // Idle mix: thirds of the run by requests taken.
    // First third: sender barely idles, receiver mostly stalls.
    // Second third: the reverse. Last third: no idling at all.
    // ------------------------------------------------------------------
    always @*
    begin
        if (req_taken * 3 < req_total)
        begin
            send_idle_pct = 9;
            recv_idle_pct = 76;
        end
        else if (req_taken * 3 < req_total * 2)
        begin
            send_idle_pct = 76;
            recv_idle_pct = 9;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // ------------------------------------------------------------------
    // Request driver. A request is taken on an edge with valid high and
    // stall low; the model sees it at that edge. A new request (or an idle
    // cycle) is put up only once the current one is gone, so a stalled
    // payload never moves.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            action      <= ACT_ABSORB;
            data_byte   <= 8'h00;
            late_finish <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                sha_take_request(action, data_byte);
                req_taken++;
                // a finish in the back half arms the long receiver hold
                if (action == ACT_FINISH && req_taken * 2 >= req_total)
                    late_finish <= 1'b1;
            end
            if (!item_valid || !item_stall)
            begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_req   = req_q.pop_front();
                    item_valid <= 1'b1;
                    action     <= next_req.act;
                    data_byte  <= next_req.data;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold, counted here on its own. While it lasts the
    // digest sits in the output stage and the block stalls the requests
    // the driver keeps offering.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (late_finish && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Result monitor and checker
    // ------------------------------------------------------------------
    function automatic void report_mismatch(input string what, input logic [31:0] exp_val,
                                            input logic [31:0] got_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s mismatch: expected %h, got %h", $realtime, what,
                     exp_val, got_val);
    endfunction

    function automatic void check_digest_word();
        digest_word_t dw;
        if (digest_q.size() == 0)
        begin
            report_mismatch("unexpected digest word", 32'h0, digest_word);
            return;
        end
        dw = digest_q.pop_front();
        words_checked++;
        if (digest_word !== dw.word)
            report_mismatch("digest_word", dw.word, digest_word);
        if (word_index !== dw.idx)
            report_mismatch("word_index", 32'(dw.idx), 32'(word_index));
        if (last_word !== dw.is_last)
            report_mismatch("last_word", 32'(dw.is_last), 32'(last_word));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_digest_word();
            result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        req_taken       = 0;
        msgs_hashed     = 0;
        empty_msgs      = 0;
        short_tail_msgs = 0;
        words_checked   = 0;
        mismatches      = 0;
        rand_msgs       = 0;
        sha_restart();

        // directed: empty message twice (finish data must not matter),
        // single bytes at both extremes, then "abc"
        queue_finish(8'h00);
        queue_finish(8'hff);
        queue_byte(8'h00);
        queue_finish(8'h5a);
        queue_byte(8'hff);
        queue_finish(8'h00);
        queue_byte(8'h61);
        queue_byte(8'h62);
        queue_byte(8'h63);
        queue_finish(8'hff);

        // random messages until enough requests and digests are lined up
        while (req_q.size() < TARGET_REQS || rand_msgs < MIN_RAND_MSG)
        begin
            msg_room = TARGET_REQS - int'(req_q.size()) - 1;
            queue_random_msg((msg_room > 0) ? msg_room : 0);
            rand_msgs++;
        end
        req_total = req_q.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all requests taken, then all digests back, then a quiet drain
        while (req_q.size() != 0 || item_valid)
            @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (digest_q.size() != 0)
            report_mismatch("missing digest words", 32'(digest_q.size()), 32'h0);

        $display("Hashed %0d messages from %0d requests: %0d empty, %0d with a spilled tail.",
                 msgs_hashed, req_taken, empty_msgs, short_tail_msgs);
        $display("Checked %0d digest words, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Timeout after %0d cycles.", LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

endmodule
